/* rtl/pvswb_pkg.sv */
// ----------------------------------------------------------------------------
// pvswb_pkg
// Shared types and constants of the paged vector store write-back buffer
// ----------------------------------------------------------------------------
package pvswb_pkg;

	localparam int PAGE_VECTORS = 16;
	localparam int MAX_PAGES    = 64;
	localparam int VECTOR_WORDS = 4;
	localparam int BUF_WORDS    = PAGE_VECTORS * VECTOR_WORDS;
	localparam int STORE_WORDS  = MAX_PAGES * BUF_WORDS;

	localparam int VI_W   = 10;
	localparam int WI_W   = 2;
	localparam int CFG_W  = 11;
	localparam int DATA_W = 64;
	localparam int PV_W   = $clog2(PAGE_VECTORS);
	localparam int VW_W   = (VECTOR_WORDS > 1) ? $clog2(VECTOR_WORDS) : 1;
	localparam int PAGE_W = $clog2(MAX_PAGES);
	localparam int OFF_W  = $clog2(BUF_WORDS);
	localparam int SADR_W = $clog2(STORE_WORDS);
	localparam int PG_RAW_W = VI_W - PV_W;

	localparam logic [1:0] MODE_BUF_RD = 2'd0;
	localparam logic [1:0] MODE_BUF_WR = 2'd1;
	localparam logic [1:0] MODE_DIR_RD = 2'd2;
	localparam logic [1:0] MODE_DIR_WR = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_ARG_ERR = 2'd1;
	localparam logic [1:0] ST_RD_ERR  = 2'd2;

	typedef struct packed {
		logic [1:0]        mode;
		logic              arg_err;
		logic [PAGE_W-1:0] page;
		logic [OFF_W-1:0]  off;
		logic [DATA_W-1:0] wdata;
	} cmd_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic [1:0]        status;
		logic              buffer_hit;
		logic              wrote_back;
		logic              page_zero_filled;
	} rsp_t;

endpackage

/* rtl/pvswb_ram.sv */
// ----------------------------------------------------------------------------
// pvswb_ram
// Generic single-port RAM with registered read
// ----------------------------------------------------------------------------
module pvswb_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

/* rtl/pvswb_front.sv */
// ----------------------------------------------------------------------------
// pvswb_front
// Range check, page and offset split, two-entry command queue
// ----------------------------------------------------------------------------
module pvswb_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [1:0]                    mode,
	input  logic [pvswb_pkg::VI_W-1:0]    vector_index,
	input  logic [pvswb_pkg::WI_W-1:0]    word_index,
	input  logic [pvswb_pkg::DATA_W-1:0]  write_data,
	input  logic [pvswb_pkg::CFG_W-1:0]   limit,
	output logic                          cmd_valid,
	output pvswb_pkg::cmd_t               cmd,
	input  logic                          cmd_take
);
	pvswb_pkg::cmd_t q_q [2];
	logic [1:0] cnt_q;
	logic       rd_q;
	pvswb_pkg::cmd_t c;
	logic [pvswb_pkg::PG_RAW_W-1:0] praw;
	logic do_push, do_pop;

	always_comb begin
		praw = vector_index[pvswb_pkg::VI_W-1:pvswb_pkg::PV_W];
		c.mode = mode;
		c.wdata = write_data;
		c.arg_err = (limit == '0) || ({1'b0, vector_index} >= limit)
			|| ({{(32-pvswb_pkg::PG_RAW_W){1'b0}}, praw} >= 32'(pvswb_pkg::MAX_PAGES))
			|| ({{(32-pvswb_pkg::WI_W){1'b0}}, word_index}
				>= 32'(pvswb_pkg::VECTOR_WORDS));
		c.page = pvswb_pkg::PAGE_W'(praw);
		c.off = pvswb_pkg::OFF_W'({vector_index[pvswb_pkg::PV_W-1:0],
			pvswb_pkg::VW_W'(word_index)});
	end

	assign full = (cnt_q == 2'd2);
	assign do_push = push && !full;
	assign cmd_valid = (cnt_q != 2'd0);
	assign do_pop = cmd_valid && cmd_take;
	assign cmd = q_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q <= 1'b0;
		end else begin
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
			if (do_pop)
				rd_q <= ~rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			q_q[rd_q ^ cnt_q[0]] <= c;
	end
endmodule

/* rtl/pvswb_back.sv */
// ----------------------------------------------------------------------------
// pvswb_back
// Executes commands against the page buffer and backing store
// ----------------------------------------------------------------------------
module pvswb_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  pvswb_pkg::cmd_t  cmd,
	output logic             cmd_take,
	output logic             empty,
	input  logic             pop,
	output logic [pvswb_pkg::DATA_W-1:0] read_data,
	output logic [1:0]       status,
	output logic             buffer_hit,
	output logic             wrote_back,
	output logic             page_zero_filled
);
	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_WB, S_WBW, S_FILL, S_FILLW, S_ZERO, S_DRD, S_DZ, S_DONE
	} state_t;

	localparam int OW = pvswb_pkg::OFF_W;

	state_t state_q;
	pvswb_pkg::cmd_t cmd_q;
	pvswb_pkg::rsp_t wrk_q;
	pvswb_pkg::rsp_t rsp_q;
	logic [OW:0] idx_q;
	logic [pvswb_pkg::PAGE_W-1:0] cur_q;
	logic dirty_q, out_q;
	logic [pvswb_pkg::MAX_PAGES-1:0] stored_q;
	logic [pvswb_pkg::BUF_WORDS-1:0] bvalid_q;

	logic b_we, s_we;
	logic [OW-1:0] b_addr;
	logic [pvswb_pkg::SADR_W-1:0] s_addr;
	logic [pvswb_pkg::DATA_W-1:0] b_wd, b_rd, s_wd, s_rd, b_val, rd_sel;
	logic hit, pst, last, done_fire, wb_direct;

	pvswb_ram #(.WIDTH(pvswb_pkg::DATA_W), .DEPTH(pvswb_pkg::BUF_WORDS)) u_buf (
		.clk(clk), .we(b_we), .addr(b_addr), .wdata(b_wd), .rdata(b_rd));
	pvswb_ram #(.WIDTH(pvswb_pkg::DATA_W), .DEPTH(pvswb_pkg::STORE_WORDS)) u_store (
		.clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wd), .rdata(s_rd));

	assign hit = (cmd_q.page == cur_q);
	assign pst = stored_q[cmd_q.page];
	assign last = (idx_q[OW-1:0] == OW'(pvswb_pkg::BUF_WORDS - 1));
	assign cmd_take = (state_q == S_IDLE);
	assign done_fire = (state_q == S_DONE) && (!out_q || pop);
	assign wb_direct = (cmd_q.mode == pvswb_pkg::MODE_DIR_WR) && !pst && hit;
	assign empty = !out_q;
	assign read_data = rsp_q.read_data;
	assign status = rsp_q.status;
	assign buffer_hit = rsp_q.buffer_hit;
	assign wrote_back = rsp_q.wrote_back;
	assign page_zero_filled = rsp_q.page_zero_filled;
	// buffer word not yet written since reset reads as zero
	assign b_val = bvalid_q[idx_q[OW-1:0]] ? b_rd : '0;
	assign rd_sel = (wrk_q.status != pvswb_pkg::ST_OK) ? '0
		: (cmd_q.mode == pvswb_pkg::MODE_BUF_RD) ? b_val
		: (cmd_q.mode == pvswb_pkg::MODE_DIR_RD) ? (wrk_q.buffer_hit ? b_val : s_rd)
		: '0;

	always_comb begin
		b_we = 1'b0;
		s_we = 1'b0;
		b_addr = cmd_q.off;
		s_addr = {cmd_q.page, cmd_q.off};
		b_wd = cmd_q.wdata;
		s_wd = cmd_q.wdata;
		unique case (state_q)
			S_RD: begin
				b_we = (cmd_q.mode == pvswb_pkg::MODE_BUF_WR)
					|| (cmd_q.mode == pvswb_pkg::MODE_DIR_WR && hit);
				s_we = (cmd_q.mode == pvswb_pkg::MODE_DIR_WR) && pst;
			end
			S_WB: b_addr = idx_q[OW-1:0];
			S_WBW: begin
				b_addr = idx_q[OW-1:0] + OW'(1);
				s_we = 1'b1;
				s_addr = {cur_q, idx_q[OW-1:0]};
				s_wd = b_val;
			end
			S_FILL: s_addr = {cmd_q.page, idx_q[OW-1:0]};
			S_FILLW: begin
				b_we = 1'b1;
				b_addr = idx_q[OW-1:0];
				b_wd = s_rd;
				s_addr = {cmd_q.page, idx_q[OW-1:0] + OW'(1)};
			end
			S_ZERO: begin
				b_we = 1'b1;
				b_addr = idx_q[OW-1:0];
				b_wd = '0;
			end
			S_DRD: ;
			S_DZ: begin
				s_we = 1'b1;
				s_addr = {cmd_q.page, idx_q[OW-1:0]};
				s_wd = (idx_q[OW-1:0] == cmd_q.off) ? cmd_q.wdata : '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_q <= 1'b0;
			cur_q <= '0;
			dirty_q <= 1'b0;
			stored_q <= '0;
			bvalid_q <= '0;
			idx_q <= '0;
			cmd_q <= '0;
			wrk_q <= '0;
			rsp_q <= '0;
		end else begin
			if (done_fire)
				out_q <= 1'b1;
			else if (out_q && pop)
				out_q <= 1'b0;
			if (b_we)
				bvalid_q[b_addr] <= 1'b1;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid && cmd_take) begin
						cmd_q <= cmd;
						wrk_q <= {{pvswb_pkg::DATA_W{1'b0}},
							cmd.arg_err ? pvswb_pkg::ST_ARG_ERR : pvswb_pkg::ST_OK, 3'b000};
						state_q <= cmd.arg_err ? S_DONE : S_DRD;
					end
				end
				S_DRD: begin
					wrk_q.buffer_hit <= hit;
					idx_q <= '0;
					if (cmd_q.mode == pvswb_pkg::MODE_BUF_RD
						|| cmd_q.mode == pvswb_pkg::MODE_BUF_WR) begin
						if (hit)
							state_q <= S_RD;
						else if (dirty_q)
							state_q <= S_WB;
						else if (pst)
							state_q <= S_FILL;
						else
							state_q <= S_ZERO;
					end else if (cmd_q.mode == pvswb_pkg::MODE_DIR_RD) begin
						if (hit)
							state_q <= S_RD;
						else if (pst)
							state_q <= S_RD;
						else begin
							wrk_q.status <= pvswb_pkg::ST_RD_ERR;
							state_q <= S_DONE;
						end
					end else begin
						if (hit || pst)
							state_q <= S_RD;
						else
							state_q <= S_DZ;
					end
				end
				S_WB: state_q <= S_WBW;
				S_WBW: begin
					if (last) begin
						idx_q <= '0;
						stored_q[cur_q] <= 1'b1;
						dirty_q <= 1'b0;
						wrk_q.wrote_back <= 1'b1;
						if (cmd_q.mode == pvswb_pkg::MODE_DIR_WR)
							state_q <= S_DONE;
						else if (pst)
							state_q <= S_FILL;
						else
							state_q <= S_ZERO;
					end else
						idx_q <= idx_q + (OW+1)'(1);
				end
				S_FILL: state_q <= S_FILLW;
				S_FILLW: begin
					idx_q <= idx_q + (OW+1)'(1);
					if (last) begin
						cur_q <= cmd_q.page;
						state_q <= S_RD;
					end
				end
				S_ZERO: begin
					idx_q <= idx_q + (OW+1)'(1);
					if (last) begin
						cur_q <= cmd_q.page;
						wrk_q.page_zero_filled <= 1'b1;
						state_q <= S_RD;
					end
				end
				S_DZ: begin
					idx_q <= idx_q + (OW+1)'(1);
					if (last) begin
						stored_q[cmd_q.page] <= 1'b1;
						wrk_q.page_zero_filled <= 1'b1;
						state_q <= S_DONE;
					end
				end
				S_RD: begin
					// buffer/store read data appears next cycle; write done here
					idx_q <= wb_direct ? '0 : {1'b0, cmd_q.off};
					state_q <= wb_direct ? S_WB : S_DONE;
					if (cmd_q.mode == pvswb_pkg::MODE_BUF_WR)
						dirty_q <= 1'b1;
				end
				S_DONE: begin
					if (done_fire) begin
						rsp_q <= {rd_sel, wrk_q.status, wrk_q.buffer_hit, wrk_q.wrote_back,
							wrk_q.page_zero_filled};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* rtl/paged_vector_store_write_back_buffer_unit.sv */
// ----------------------------------------------------------------------------
// paged_vector_store_write_back_buffer_unit
// Paged vector store with a one-page write-back buffer
// ----------------------------------------------------------------------------
// Input channel: push/full with mode, vector_index, word_index, write_data.
// Result channel: empty/pop with read_data, status, buffer_hit, wrote_back,
// page_zero_filled; one result per transaction, in order.
// vectors_in_use is written through cfg_we/cfg_wdata; the user must write
// it only while idle, as the block itself does not enforce this.
// A front part range-checks each transaction and splits it into page and
// offset into a two-entry queue; a back part runs one command at a time.
// A buffer hit passes the back part steps take, decode, RAM access and
// result; the back part takes the next command only when the last one is
// done. A miss adds one word per cycle for each page copy of 64 words:
// write-back of a dirty page and fill from the backing store or zero fill.
// A direct write to an unstored page creates it word by word in place of the
// access step, or, if it is the buffered page, writes the buffer back.
// Reset empties the queue and leaves page 0 buffered, clean and zero.
// While the result is not popped the back part finishes the next command and
// holds it; the queue then fills and full rises.
// ----------------------------------------------------------------------------
module paged_vector_store_write_back_buffer_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [1:0]                    mode,
	input  logic [pvswb_pkg::VI_W-1:0]    vector_index,
	input  logic [pvswb_pkg::WI_W-1:0]    word_index,
	input  logic [pvswb_pkg::DATA_W-1:0]  write_data,
	output logic                          empty,
	input  logic                          pop,
	output logic [pvswb_pkg::DATA_W-1:0]  read_data,
	output logic [1:0]                    status,
	output logic                          buffer_hit,
	output logic                          wrote_back,
	output logic                          page_zero_filled,
	input  logic                          cfg_we,
	input  logic [pvswb_pkg::CFG_W-1:0]   cfg_wdata
);
	logic [pvswb_pkg::CFG_W-1:0] limit_q;
	logic cmd_valid, cmd_take;
	pvswb_pkg::cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			limit_q <= pvswb_pkg::CFG_W'(1024);
		else if (cfg_we)
			limit_q <= cfg_wdata;
	end

	pvswb_front u_front (
		.clk, .arst_n, .push, .full, .mode, .vector_index, .word_index,
		.write_data, .limit(limit_q), .cmd_valid, .cmd, .cmd_take);

	pvswb_back u_back (
		.clk, .arst_n, .cmd_valid, .cmd, .cmd_take, .empty, .pop, .read_data,
		.status, .buffer_hit, .wrote_back, .page_zero_filled);
endmodule

/* rtl/pvswb_checker.sv */
// ----------------------------------------------------------------------------
// pvswb_assert
// Port-level checks of the paged vector store write-back buffer
// ----------------------------------------------------------------------------
module pvswb_assert (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [1:0] status,
	input logic [63:0] read_data,
	input logic       buffer_hit,
	input logic       wrote_back,
	input logic       page_zero_filled
);
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> status <= pvswb_pkg::ST_RD_ERR) else $error("bad status");
	a_err_data: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && status != pvswb_pkg::ST_OK |-> read_data == '0) else $error("error data");
	a_arg_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && status == pvswb_pkg::ST_ARG_ERR
			|-> !buffer_hit && !wrote_back && !page_zero_filled)
		else $error("argument error flags");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(read_data)) else $error("result lost");
endmodule

bind paged_vector_store_write_back_buffer_unit pvswb_assert u_checker (
	.clk, .arst_n, .empty, .pop, .status, .read_data, .buffer_hit,
	.wrote_back, .page_zero_filled);
